/* src/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the star wildcard matcher
// Request codes, beat payload structs and the structs passed between cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_SUBJECT = 2'd1,
    REQ_END     = 2'd2,
    REQ_CLEAR   = 2'd3
  } swm_req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] ch;
  } swm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } swm_out_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic       rearm;
    logic       consume;
    logic       append;
    logic       clear;
    logic [7:0] ch;
  } swm_ctl_t;

  // rightward: active bit of the position left of the next cell, fill bit, closure
  typedef struct packed {
    logic act;
    logic used;
    logic carry;
  } swm_fwd_t;

  // leftward: fill bit and star self-loop for the position owned by the left cell
  typedef struct packed {
    logic used;
    logic keep;
  } swm_bwd_t;

endpackage

/* src/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell: one pattern slot of the matcher chain
// Holds one pattern byte, its fill bit and the active bit of the position
// just after that byte; updates from its neighbors on every beat.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swm_pkg::swm_ctl_t ctl_i,
  input  swm_pkg::swm_fwd_t fwd_i,
  output swm_pkg::swm_fwd_t fwd_o,
  input  swm_pkg::swm_bwd_t bwd_i,
  output swm_pkg::swm_bwd_t bwd_o,
  output logic             hit_o
);
  import swm_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic       used_q, used_d;
  logic       act_q, act_d;
  logic       star_cur, star_next;
  logic       hop, reach;

  assign star_cur = (byte_q == STAR_BYTE);

  // literal byte advances from the left position into ours
  assign hop        = ctl_i.consume & fwd_i.act & used_q & ~star_cur & (byte_q == ctl_i.ch);
  assign bwd_o.keep = ctl_i.consume & fwd_i.act & used_q & star_cur;
  assign bwd_o.used = used_q;

  always_comb begin
    used_d = used_q;
    byte_d = byte_q;
    if (ctl_i.clear) begin
      used_d = 1'b0;
    end else if (ctl_i.append) begin
      used_d = used_q | fwd_i.used;
      if (fwd_i.used && !used_q) begin
        byte_d = ctl_i.ch;
      end
    end
  end

  // closure runs over the pattern as it stands after this beat
  assign star_next = used_d & (byte_d == STAR_BYTE);
  assign reach     = hop | bwd_i.keep | (fwd_i.carry & star_next);
  assign act_d     = (ctl_i.rearm | ctl_i.consume) ? reach : act_q;

  assign fwd_o.act   = act_q;
  assign fwd_o.used  = used_q;
  assign fwd_o.carry = reach;

  // our position is the end of the pattern
  assign hit_o = act_q & used_q & ~bwd_i.used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      act_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

/* src/star_wildcard_matcher.sv */
// ----------------------------------------------------------------------------
// star_wildcard_matcher: whole-string match with '*' as the only wildcard
// Pattern bytes fill a chain of cells; subject bytes update every position of
// the chain in parallel, one byte per cycle while in_stall_o is low.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while in_stall_o is low, set by the update of the cell chain
// the result of an end-of-subject beat is registered in the output register, or in the skid stage
// a two-entry output register and skid stage hold results while the sink stalls
// reset: empty pattern, position zero active, no overflow, no result pending
module star_wildcard_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  swm_pkg::swm_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output swm_pkg::swm_out_t out_data_o
);
  import swm_pkg::*;

  swm_ctl_t ctl;
  swm_fwd_t fwd [MAX_PATTERN+1];
  swm_bwd_t bwd [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] used_vec;

  logic     accept, is_end;
  logic     head_act_q, head_act_d, head_reach;
  logic     ovf_q, ovf_d;
  logic     matched;
  swm_out_t res;
  logic     out_valid_q, skid_valid_q;
  swm_out_t out_q, skid_q;
  logic     out_free;

  assign accept = in_valid_i & ~in_stall_o;

  always_comb begin
    ctl    = '0;
    is_end = 1'b0;
    ctl.ch = in_data_i.ch;
    unique case (in_data_i.req_type)
      REQ_APPEND: begin
        ctl.append = accept;
        ctl.rearm  = accept;
      end
      REQ_SUBJECT: begin
        ctl.consume = accept;
      end
      REQ_END: begin
        ctl.rearm = accept;
        is_end    = accept;
      end
      REQ_CLEAR: begin
        ctl.clear = accept;
        ctl.rearm = accept;
      end
      default: begin
        ctl.rearm = 1'b0;
      end
    endcase
  end

  // position zero lives here, ahead of the first cell
  assign head_reach = ctl.rearm | bwd[0].keep;
  assign head_act_d = (ctl.rearm | ctl.consume) ? head_reach : head_act_q;

  assign fwd[0].act   = head_act_q;
  assign fwd[0].used  = 1'b1;
  assign fwd[0].carry = head_reach;
  assign bwd[MAX_PATTERN] = '0;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    swm_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .fwd_i (fwd[k]),
      .fwd_o (fwd[k+1]),
      .bwd_i (bwd[k+1]),
      .bwd_o (bwd[k]),
      .hit_o (hit[k])
    );
    assign used_vec[k] = bwd[k].used;
  end

  assign matched = (head_act_q & ~used_vec[0]) | (|hit);

  always_comb begin
    ovf_d = ovf_q;
    if (ctl.clear) begin
      ovf_d = 1'b0;
    end else if (ctl.append && used_vec[MAX_PATTERN-1]) begin
      ovf_d = 1'b1;
    end
  end

  assign res.matched          = matched;
  assign res.pattern_overflow = ovf_q;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_act_q   <= 1'b1;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_act_q <= head_act_d;
      ovf_q      <= ovf_d;
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= is_end;
        end else begin
          out_valid_q <= is_end;
        end
      end else if (is_end) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (is_end) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // pattern fill stays a contiguous prefix
  a_fill_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("pattern fill has a gap");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> used_vec[MAX_PATTERN-1])
    else $error("overflow flagged with room left");

  // a rearming beat always leaves position zero active
  a_rearm_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rearm |=> head_act_q)
    else $error("position zero inactive after rearm");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> (!used_vec[0] && !ovf_q))
    else $error("pattern not empty after clear");

endmodule
